// ===== design/prr_pkg.sv =====
// ============================================================================
// prr_pkg - shared definitions for the polyphase rational resampler
// Sample and coefficient formats, register map codes, operation codes and
// the sequencer state type.
// ============================================================================
`default_nettype none

package prr_pkg;

    // Fixed field formats: samples are Q1.15, coefficients are Q2.16.
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int COEF_ADDR_BITS = 11;

    // Dot product is scaled back by the coefficient fraction bits.
    localparam int SHIFT_BITS = COEF_BITS - 2;

    // Phase accumulator width.
    localparam int PHASE_BITS = 11;

    // Configuration register widths.
    localparam int INTERP_BITS = 6;
    localparam int DECIM_BITS  = 10;
    localparam int TAPS_BITS   = 7;

    // Configuration register reset values.
    localparam int CFG_TAPS_RST = 64;

    // Default storage depths.
    localparam int DEF_MAX_PHASES = 32;
    localparam int DEF_MAX_TAPS   = 64;

    // APB port geometry.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Operation codes of an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_INTERP = 2'd1,
        REG_DECIM  = 2'd2,
        REG_TAPS   = 2'd3
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BASE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } state_t;

endpackage

`default_nettype wire

// ===== design/polyphase_rational_resampler_core.sv =====
// ============================================================================
// polyphase_rational_resampler_core - rational L/M polyphase FIR resampler
// One shared multiply-accumulate unit under a small sequencer computes each
// output as the dot product of one coefficient bank with the sample ring.
// ============================================================================
// Coefficient load item: the sequencer stays idle, so the block can take the next item unless the output is stalled.
// Sample item with enable low: the sample is registered straight into the output register.
// Sample item giving R results over T taps: each result passes the base, multiply-accumulate,
// drain and round states of the single multiply-accumulate unit, which handles one tap per cycle.
// Reset clears the sequencer, the output valid flag, the phase and the ring valid bits,
// sets the write pointer to the last entry of the default ring; registers return to their default values.
`default_nettype none

module polyphase_rational_resampler_core #(
    parameter int MAX_PHASES = prr_pkg::DEF_MAX_PHASES,
    parameter int MAX_TAPS   = prr_pkg::DEF_MAX_TAPS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // Input channel.
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  operation,
    input  wire logic signed [prr_pkg::SAMPLE_BITS-1:0]    sample_in,
    input  wire logic        [prr_pkg::COEF_ADDR_BITS-1:0] coef_addr,
    input  wire logic signed [prr_pkg::COEF_BITS-1:0]      coef_value,

    // Output channel.
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [prr_pkg::SAMPLE_BITS-1:0]     sample_out,
    output logic                                       last_of_run,

    // Configuration port.
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [prr_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [prr_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic      [prr_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                       pready
);

    // Derived widths and constants.
    localparam int COEF_DEPTH = MAX_PHASES * MAX_TAPS;
    localparam int CA_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int PTR_W      = $clog2(MAX_TAPS);
    localparam int TAPS_W     = $clog2(MAX_TAPS + 1);
    localparam int L_W        = $clog2(MAX_PHASES + 1);
    localparam int PROD_W     = prr_pkg::SAMPLE_BITS + prr_pkg::COEF_BITS;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);
    localparam int RQ_W       = ACC_W - prr_pkg::SHIFT_BITS + 1;
    localparam int BP_W       = prr_pkg::PHASE_BITS + TAPS_W;
    localparam int WP_RST_INT =
        ((MAX_TAPS < prr_pkg::CFG_TAPS_RST) ? MAX_TAPS : prr_pkg::CFG_TAPS_RST) - 1;
    localparam logic [PTR_W-1:0] WP_RST = PTR_W'(WP_RST_INT);
    localparam logic signed [RQ_W-1:0] Q_MAX = RQ_W'((2 ** (prr_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RQ_W-1:0] Q_MIN = -RQ_W'(2 ** (prr_pkg::SAMPLE_BITS - 1));
    localparam logic signed [ACC_W:0]  RND_HALF = (ACC_W + 1)'(2 ** (prr_pkg::SHIFT_BITS - 1));

    // Configuration registers.
    logic                               enable_reg;
    logic [prr_pkg::INTERP_BITS-1:0]    interp_reg;
    logic [prr_pkg::DECIM_BITS-1:0]     decim_reg;
    logic [prr_pkg::TAPS_BITS-1:0]      taps_reg;

    // Sequencer and datapath state.
    prr_pkg::state_t                    state_reg, state_next;
    logic [prr_pkg::PHASE_BITS-1:0]     phase_reg, phase_next;
    logic [PTR_W-1:0]                   wp_reg, wp_next;
    logic [CA_W-1:0]                    ca_reg, ca_next;
    logic [PTR_W-1:0]                   ri_reg, ri_next;
    logic [PTR_W-1:0]                   j_reg, j_next;

    // Memories and ring valid bits.
    logic signed [prr_pkg::COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
    logic signed [prr_pkg::SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]                    ring_vld_reg;

    // Multiply-accumulate pipeline.
    logic signed [prr_pkg::COEF_BITS-1:0]   coef_q_reg;
    logic signed [prr_pkg::SAMPLE_BITS-1:0] ring_q_reg;
    logic                                   ring_hit_reg;
    logic                                   rd_vld_reg;
    logic signed [PROD_W-1:0]               prod_reg;
    logic                                   prod_vld_reg;
    logic signed [ACC_W-1:0]                acc_reg;

    // Output register.
    logic                                   out_valid_reg;
    logic signed [prr_pkg::SAMPLE_BITS-1:0] sample_out_reg;
    logic                                   last_reg;

    // Control strobes.
    logic in_accept;
    logic out_free;
    logic cfg_wr;
    logic coef_wr;
    logic ring_wr;
    logic bypass_ld;
    logic round_ld;
    logic issue;
    logic acc_clr;

    // Effective register values and helpers.
    logic [31:0]                        l_raw;
    logic [31:0]                        t_raw;
    logic [L_W-1:0]                     l_eff;
    logic [prr_pkg::DECIM_BITS-1:0]     m_eff;
    logic [TAPS_W-1:0]                  t_eff;
    logic [PTR_W-1:0]                   t_last;
    logic [PTR_W-1:0]                   wp_clamp;
    logic [BP_W-1:0]                    base_prod;
    logic [prr_pkg::PHASE_BITS-1:0]     phase_sum;
    logic [prr_pkg::PHASE_BITS-1:0]     l_ext;
    logic                               run_last;
    logic [31:0]                        addr_ext;
    logic [CA_W-1:0]                    coef_wr_idx;
    logic                               addr_ok;
    logic signed [prr_pkg::SAMPLE_BITS-1:0] samp_op;
    logic signed [ACC_W:0]              rnd_sum;
    logic signed [RQ_W-1:0]             rnd_q;
    logic signed [prr_pkg::SAMPLE_BITS-1:0] rnd_sat;
    prr_pkg::reg_idx_t                  cfg_idx;

    // Handshakes.
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != prr_pkg::ST_IDLE) || (out_valid_reg && out_stall);

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign last_of_run = last_reg;

    // Register values clamped to the supported ranges.
    assign l_raw = 32'(interp_reg);
    assign t_raw = 32'(taps_reg);
    assign l_eff = (l_raw == 32'd0) ? L_W'(1)
                 : (l_raw > 32'(MAX_PHASES)) ? L_W'(MAX_PHASES) : L_W'(l_raw);
    assign m_eff = (decim_reg == '0) ? prr_pkg::DECIM_BITS'(1) : decim_reg;
    assign t_eff = (t_raw == 32'd0) ? TAPS_W'(1)
                 : (t_raw > 32'(MAX_TAPS)) ? TAPS_W'(MAX_TAPS) : TAPS_W'(t_raw);
    assign t_last   = PTR_W'(t_eff - TAPS_W'(1));
    assign wp_clamp = (TAPS_W'(wp_reg) >= t_eff) ? t_last : wp_reg;

    // Phase arithmetic and the base address of the current bank.
    assign l_ext     = prr_pkg::PHASE_BITS'(l_eff);
    assign phase_sum = phase_reg + prr_pkg::PHASE_BITS'(m_eff);
    assign run_last  = (phase_sum >= l_ext);
    assign base_prod = BP_W'(phase_reg) * BP_W'(t_eff);

    // Load address decode; writes beyond the memory are dropped.
    assign addr_ext    = 32'(coef_addr);
    assign addr_ok     = (addr_ext < 32'(COEF_DEPTH));
    assign coef_wr_idx = addr_ext[CA_W-1:0];

    // Rounding (half up) and saturation of the finished sum.
    assign rnd_sum = {acc_reg[ACC_W-1], acc_reg} + RND_HALF;
    assign rnd_q   = rnd_sum[ACC_W:prr_pkg::SHIFT_BITS];

    always_comb
    begin
        if (rnd_q > Q_MAX)
        begin
            rnd_sat = Q_MAX[prr_pkg::SAMPLE_BITS-1:0];
        end
        else if (rnd_q < Q_MIN)
        begin
            rnd_sat = Q_MIN[prr_pkg::SAMPLE_BITS-1:0];
        end
        else
        begin
            rnd_sat = rnd_q[prr_pkg::SAMPLE_BITS-1:0];
        end
    end

    // Configuration port: always ready, written in the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = prr_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            interp_reg <= prr_pkg::INTERP_BITS'(1);
            decim_reg  <= prr_pkg::DECIM_BITS'(1);
            taps_reg   <= prr_pkg::TAPS_BITS'(prr_pkg::CFG_TAPS_RST);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                prr_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                prr_pkg::REG_INTERP: interp_reg <= pwdata[prr_pkg::INTERP_BITS-1:0];
                prr_pkg::REG_DECIM:  decim_reg  <= pwdata[prr_pkg::DECIM_BITS-1:0];
                prr_pkg::REG_TAPS:   taps_reg   <= pwdata[prr_pkg::TAPS_BITS-1:0];
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            prr_pkg::REG_ENABLE: prdata = prr_pkg::APB_DATA_BITS'(enable_reg);
            prr_pkg::REG_INTERP: prdata = prr_pkg::APB_DATA_BITS'(interp_reg);
            prr_pkg::REG_DECIM:  prdata = prr_pkg::APB_DATA_BITS'(decim_reg);
            prr_pkg::REG_TAPS:   prdata = prr_pkg::APB_DATA_BITS'(taps_reg);
        endcase
    end

    // Sequencer: next state and control strobes.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        wp_next    = wp_reg;
        ca_next    = ca_reg;
        ri_next    = ri_reg;
        j_next     = j_reg;
        coef_wr    = 1'b0;
        ring_wr    = 1'b0;
        bypass_ld  = 1'b0;
        round_ld   = 1'b0;
        issue      = 1'b0;
        acc_clr    = 1'b0;

        unique case (state_reg)
            prr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == prr_pkg::OP_LOAD)
                    begin
                        coef_wr = addr_ok;
                    end
                    else if (!enable_reg)
                    begin
                        bypass_ld = 1'b1;
                    end
                    else
                    begin
                        ring_wr    = 1'b1;
                        wp_next    = wp_clamp;
                        state_next = prr_pkg::ST_CHECK;
                    end
                end
            end

            prr_pkg::ST_CHECK:
            begin
                // Another result is due while the phase is below L.
                if (phase_reg < l_ext)
                begin
                    state_next = prr_pkg::ST_BASE;
                end
                else
                begin
                    phase_next = phase_reg - l_ext;
                    wp_next    = (wp_reg == '0) ? t_last : wp_reg - PTR_W'(1);
                    state_next = prr_pkg::ST_IDLE;
                end
            end

            prr_pkg::ST_BASE:
            begin
                ca_next    = base_prod[CA_W-1:0];
                ri_next    = wp_reg;
                j_next     = '0;
                acc_clr    = 1'b1;
                state_next = prr_pkg::ST_MAC;
            end

            prr_pkg::ST_MAC:
            begin
                // One tap read per cycle; the ring index wraps at T.
                issue   = 1'b1;
                ca_next = ca_reg + CA_W'(1);
                ri_next = (ri_reg == t_last) ? '0 : ri_reg + PTR_W'(1);
                j_next  = j_reg + PTR_W'(1);
                if (j_reg == t_last)
                begin
                    state_next = prr_pkg::ST_DRAIN;
                end
            end

            prr_pkg::ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = prr_pkg::ST_ROUND;
                end
            end

            prr_pkg::ST_ROUND:
            begin
                if (out_free)
                begin
                    round_ld   = 1'b1;
                    phase_next = phase_sum;
                    state_next = prr_pkg::ST_CHECK;
                end
            end

            default:
            begin
                state_next = prr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer and pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prr_pkg::ST_IDLE;
            phase_reg <= '0;
            wp_reg    <= WP_RST;
            ca_reg    <= '0;
            ri_reg    <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            ca_reg    <= ca_next;
            ri_reg    <= ri_next;
            j_reg     <= j_next;
        end
    end

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[coef_wr_idx] <= coef_value;
        end
        if (issue)
        begin
            coef_q_reg <= coef_mem[ca_reg];
        end
    end

    // Sample ring: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[wp_clamp] <= sample_in;
        end
        if (issue)
        begin
            ring_q_reg   <= ring_mem[ri_reg];
            ring_hit_reg <= ring_vld_reg[ri_reg];
        end
    end

    // Ring valid bits; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
        end
        else if (ring_wr)
        begin
            ring_vld_reg[wp_clamp] <= 1'b1;
        end
    end

    // Multiply-accumulate pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    assign samp_op = ring_hit_reg ? ring_q_reg : '0;

    // Product and accumulator.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= PROD_W'(samp_op) * PROD_W'(coef_q_reg);
        end
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Output register: filled by bypass or by a finished result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (bypass_ld || round_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bypass_ld)
        begin
            sample_out_reg <= sample_in;
            last_reg       <= 1'b1;
        end
        else if (round_ld)
        begin
            sample_out_reg <= rnd_sat;
            last_reg       <= run_last;
        end
    end

    // The ring read index stays inside the ring in use.
    a_ring_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prr_pkg::ST_MAC) |-> (TAPS_W'(ri_reg) < t_eff))
        else $error("ring read index outside the ring in use");

    // A bank is only started while the phase is below L.
    a_bank_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prr_pkg::ST_BASE) |-> (phase_reg < l_ext))
        else $error("bank started with phase at or above L");

    // Products only flow while a dot product is being formed.
    a_mac_window: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> (state_reg == prr_pkg::ST_MAC || state_reg == prr_pkg::ST_DRAIN))
        else $error("product outside the accumulation window");

    // A coefficient load never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && operation == prr_pkg::OP_LOAD && !out_valid_reg) |=> !out_valid_reg)
        else $error("coefficient load produced a result");

endmodule

`default_nettype wire
